>>> rtl/at_rlc_pkg.sv
// Shared types and constants for the AT response line classifier.
`timescale 1ns / 1ps

package at_rlc_pkg;

  localparam int LINE_BYTES_DEF    = 256;
  localparam int PATTERN_BYTES_DEF = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] LF_CODE   = 8'h0A;
  localparam logic [7:0] CR_CODE   = 8'h0D;
  localparam logic [7:0] SKIP_CODE = 8'hFF;
  localparam logic [7:0] NUL_CODE  = 8'h00;

  // Keywords, last byte in bits 7..0 so byte j matches window cell j.
  localparam logic [63:0] OK_WORD    = 64'h0000_0000_0000_4F4B;
  localparam logic [63:0] ERROR_WORD = 64'h0000_0045_5252_4F52;
  localparam int          OK_LEN     = 2;
  localparam int          ERROR_LEN  = 5;

  localparam logic [7:0] OK_REPORT      = 8'd2;
  localparam logic [7:0] ERROR_REPORT   = 8'd5;
  localparam logic [7:0] TIMEOUT_REPORT = 8'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EXPECT_PATTERN = 1'b0,
    REG_EXPECT_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    KIND_PRIMARY      = 3'd0,
    KIND_OK           = 3'd1,
    KIND_ERROR        = 3'd2,
    KIND_INTERMEDIATE = 3'd3,
    KIND_TIMEOUT      = 3'd4,
    KIND_ACCEPTED     = 3'd5,
    KIND_REFUSED      = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [31:0] tmo_ticks;
  } in_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] report_length;
  } out_t;

  // Compare flags of one window cell against the byte it is about to hold.
  typedef struct packed {
    logic pat;
    logic ok;
    logic err;
  } cell_eq_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

>>> rtl/at_rlc_cell.sv
// One byte cell of the sliding text window, with its keyword compares.
`timescale 1ns / 1ps

module at_rlc_cell (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [7:0]          d_in,
  input  logic [7:0]          pat_byte,
  input  logic [7:0]          ok_byte,
  input  logic [7:0]          err_byte,
  output logic [7:0]          q,
  output at_rlc_pkg::cell_eq_t eq
);
  import at_rlc_pkg::*;

  logic [7:0] byte_r;

  // Bytes beyond the text length are never looked at, so no reset.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign q      = byte_r;
  assign eq.pat = (d_in == pat_byte);
  assign eq.ok  = (d_in == ok_byte);
  assign eq.err = (d_in == err_byte);

endmodule

>>> rtl/at_rlc_outbuf.sv
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps

module at_rlc_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  at_rlc_pkg::out_t       push_data,
  output logic                   can_accept,
  output logic                   out_valid,
  input  logic                   out_ready,
  output at_rlc_pkg::out_t       out_data,
  output at_rlc_pkg::buf_status_t status
);
  import at_rlc_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  out_t out_r;
  out_t skid_r;
  logic pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else if (!push) begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= push_data;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

  assign can_accept        = !skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;
  assign status.out_valid  = out_valid_r;
  assign status.skid_valid = skid_valid_r;

endmodule

>>> rtl/at_response_line_classifier.sv
// Top level of the AT response line classifier.
`timescale 1ns / 1ps

// AT response line classifier.
// Input channel (in_valid/in_ready/in_data) carries one event per transfer:
// a received modem byte, a one millisecond tick or a command start. The
// result channel (out_valid/out_ready/out_data) carries at most one result
// per input transfer: line class and reported length, timeout, or the
// accept/refuse answer to a start.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 expected pattern, 1 pattern length) at the clock edge; idle use only.
// Throughput: one input transfer per cycle. Every event is resolved in the
// cycle it is taken, through a row of byte cells that shift the newest text
// bytes and compare them in parallel against pattern, "OK" and "ERROR".
// Latency: with the result buffer empty, a result is on out_data the cycle
// after its input transfer.
// Stall: results go to an output register backed by a skid entry; input is
// still taken while one result waits, and in_ready drops only when both
// entries are full.
// Reset (rst_n low, synchronous): idle, line state, counters and both
// configuration registers cleared, result buffer emptied.
module at_response_line_classifier #(
  parameter int LINE_BYTES    = at_rlc_pkg::LINE_BYTES_DEF,
  parameter int PATTERN_BYTES = at_rlc_pkg::PATTERN_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  at_rlc_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output at_rlc_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic [at_rlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [at_rlc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import at_rlc_pkg::*;

  localparam int LCW       = $clog2(LINE_BYTES);
  localparam int WIN_DEPTH = (PATTERN_BYTES > ERROR_LEN) ? PATTERN_BYTES : ERROR_LEN;

  // Configuration
  logic [63:0] expect_pattern_r;
  logic [3:0]  expect_length_r;

  // Command and line state
  logic           busy_r, busy_nxt;
  logic [LCW-1:0] line_count_r, line_count_nxt;
  logic [LCW-1:0] text_len_r, text_len_nxt;
  logic           nul_seen_r, nul_seen_nxt;
  logic [7:0]     first_byte_r, first_byte_nxt;
  logic           expect_hit_r, expect_hit_nxt;
  logic           ok_hit_r, ok_hit_nxt;
  logic           error_hit_r, error_hit_nxt;
  logic [31:0]    elapsed_r, elapsed_nxt;
  logic [31:0]    limit_r, limit_nxt;

  logic        accept;
  logic        store;
  logic        shift_en;
  logic [3:0]  pat_n;
  logic        push;
  out_t        res;
  logic [7:0]  text_rep;
  logic        blank;
  logic        can_accept;
  buf_status_t buf_status;

  // Window cells
  logic [7:0]     cell_d [WIN_DEPTH];
  logic [7:0]     cell_q [WIN_DEPTH];
  cell_eq_t       cell_eq [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] pat_eq, ok_eq, err_eq, pat_mask, ok_mask, err_mask;

  assign accept   = in_valid && in_ready;
  assign in_ready = can_accept;

  assign store = (32'(line_count_r) < 32'(LINE_BYTES - 1)) &&
                 (in_data.data_byte != SKIP_CODE);
  assign shift_en = accept && (in_data.action == ACT_BYTE) && store &&
                    !nul_seen_r && (in_data.data_byte != NUL_CODE);

  // Lengths above the window act as the full window.
  assign pat_n = (32'(expect_length_r) > 32'(PATTERN_BYTES)) ?
                 4'(PATTERN_BYTES) : expect_length_r;

  for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
    localparam logic [7:0] PAT_BYTE_OK  = (j < OK_LEN) ? OK_WORD[8*j +: 8] : 8'h00;
    localparam logic [7:0] PAT_BYTE_ERR = (j < ERROR_LEN) ? ERROR_WORD[8*j +: 8] : 8'h00;
    logic [7:0] pat_byte;

    if (j == 0) begin : g_head
      assign cell_d[j] = in_data.data_byte;
    end else begin : g_link
      assign cell_d[j] = cell_q[j-1];
    end

    if (j < PATTERN_BYTES) begin : g_pat
      assign pat_byte = expect_pattern_r[8*j +: 8];
    end else begin : g_nopat
      assign pat_byte = 8'h00;
    end

    at_rlc_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (cell_d[j]),
      .pat_byte (pat_byte),
      .ok_byte  (PAT_BYTE_OK),
      .err_byte (PAT_BYTE_ERR),
      .q        (cell_q[j]),
      .eq       (cell_eq[j])
    );

    assign pat_eq[j]   = cell_eq[j].pat;
    assign ok_eq[j]    = cell_eq[j].ok;
    assign err_eq[j]   = cell_eq[j].err;
    assign pat_mask[j] = (32'(j) < 32'(pat_n));
    assign ok_mask[j]  = (j < OK_LEN);
    assign err_mask[j] = (j < ERROR_LEN);
  end

  // Next-state and result
  always_comb begin
    busy_nxt       = busy_r;
    line_count_nxt = line_count_r;
    text_len_nxt   = text_len_r;
    nul_seen_nxt   = nul_seen_r;
    first_byte_nxt = first_byte_r;
    expect_hit_nxt = expect_hit_r;
    ok_hit_nxt     = ok_hit_r;
    error_hit_nxt  = error_hit_r;
    elapsed_nxt    = elapsed_r;
    limit_nxt      = limit_r;
    push           = 1'b0;
    res            = '0;
    blank          = 1'b0;
    text_rep       = 8'h00;

    case (in_data.action)
      ACT_BYTE: begin
        if (store) begin
          if (line_count_r == '0) begin
            first_byte_nxt = in_data.data_byte;
          end
          line_count_nxt = line_count_r + 1'b1;
          if (!nul_seen_r) begin
            if (in_data.data_byte == NUL_CODE) begin
              nul_seen_nxt = 1'b1;
            end else begin
              text_len_nxt = text_len_r + 1'b1;
              if ((pat_n != 4'd0) && (32'(text_len_nxt) >= 32'(pat_n)) &&
                  (&(pat_eq | ~pat_mask))) begin
                expect_hit_nxt = 1'b1;
              end
              if ((32'(text_len_nxt) >= 32'(OK_LEN)) && (&(ok_eq | ~ok_mask))) begin
                ok_hit_nxt = 1'b1;
              end
              if ((32'(text_len_nxt) >= 32'(ERROR_LEN)) && (&(err_eq | ~err_mask))) begin
                error_hit_nxt = 1'b1;
              end
            end
          end
        end
        if (in_data.data_byte == LF_CODE) begin
          blank = (text_len_nxt == '0) || (first_byte_nxt == CR_CODE) ||
                  (first_byte_nxt == LF_CODE);
          text_rep = (32'(text_len_nxt) > 32'd255) ? 8'hFF : 8'(text_len_nxt);
          if (busy_r && !blank) begin
            push = 1'b1;
            if (expect_hit_nxt) begin
              res.result_kind   = KIND_PRIMARY;
              res.report_length = text_rep;
            end else if (ok_hit_nxt) begin
              res.result_kind   = KIND_OK;
              res.report_length = OK_REPORT;
              busy_nxt          = 1'b0;
            end else if (error_hit_nxt) begin
              res.result_kind   = KIND_ERROR;
              res.report_length = ERROR_REPORT;
              busy_nxt          = 1'b0;
            end else begin
              res.result_kind   = KIND_INTERMEDIATE;
              res.report_length = text_rep;
            end
          end
          // Line done: window contents are ignored once the length is zero.
          line_count_nxt = '0;
          text_len_nxt   = '0;
          nul_seen_nxt   = 1'b0;
          first_byte_nxt = 8'h00;
          expect_hit_nxt = 1'b0;
          ok_hit_nxt     = 1'b0;
          error_hit_nxt  = 1'b0;
        end
      end
      ACT_TICK: begin
        if (busy_r) begin
          if (elapsed_r != 32'hFFFF_FFFF) begin
            elapsed_nxt = elapsed_r + 32'd1;
          end
          if (elapsed_nxt >= limit_r) begin
            busy_nxt          = 1'b0;
            push              = 1'b1;
            res.result_kind   = KIND_TIMEOUT;
            res.report_length = TIMEOUT_REPORT;
          end
        end
      end
      ACT_START: begin
        push = 1'b1;
        if (busy_r) begin
          res.result_kind = KIND_REFUSED;
        end else begin
          busy_nxt        = 1'b1;
          elapsed_nxt     = 32'd0;
          limit_nxt       = in_data.tmo_ticks;
          res.result_kind = KIND_ACCEPTED;
        end
      end
      default: begin
        // unused action code: nothing happens
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      line_count_r <= '0;
      text_len_r   <= '0;
      nul_seen_r   <= 1'b0;
      first_byte_r <= 8'h00;
      expect_hit_r <= 1'b0;
      ok_hit_r     <= 1'b0;
      error_hit_r  <= 1'b0;
      elapsed_r    <= 32'd0;
      limit_r      <= 32'd0;
    end else if (accept) begin
      busy_r       <= busy_nxt;
      line_count_r <= line_count_nxt;
      text_len_r   <= text_len_nxt;
      nul_seen_r   <= nul_seen_nxt;
      first_byte_r <= first_byte_nxt;
      expect_hit_r <= expect_hit_nxt;
      ok_hit_r     <= ok_hit_nxt;
      error_hit_r  <= error_hit_nxt;
      elapsed_r    <= elapsed_nxt;
      limit_r      <= limit_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_pattern_r <= 64'd0;
      expect_length_r  <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECT_PATTERN: expect_pattern_r <= cfg_wdata;
        REG_EXPECT_LENGTH:  expect_length_r  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  at_rlc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && push),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .status     (buf_status)
  );

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    buf_status.skid_valid |-> buf_status.out_valid)
    else $error("skid entry full while output register empty");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && buf_status.skid_valid))
    else $error("input stalled with room in the result buffer");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.action == ACT_START) && !busy_r) |=> busy_r)
    else $error("accepted start did not set busy");

  a_timeout_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.action == ACT_TICK) && busy_r && (elapsed_nxt >= limit_r))
    |=> (!busy_r && out_valid))
    else $error("timeout did not end the command with a result");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the AT response line classifier.
`timescale 1ns / 1ps

// Stimulus: a short directed run, then ten phases of random command
// sequences. Each phase has its own pattern setting, and the registers are
// written only once the block has gone quiet.
// A command sequence is a start, then a few lines (pattern text, OK, ERROR,
// others) with ticks between them. The rest is noise, broken lines and over-long lines.
// A model inside the testbench follows every accepted input transfer and
// queues the response it should produce. The monitor checks every result
// transfer against the oldest queued response.
module tb_top;
  import at_rlc_pkg::*;

  localparam int IDLE_PCT   = 21;
  localparam int PHASE_ITEMS = 100;
  localparam int WIN_CELLS   = 8;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  at_response_line_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Free-running cycle count; both sides stop idling for a stretch of it.
  int   cyc = 0;
  logic calm;
  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= 800) && (cyc < 1400);

  // ------------------------------------------------------------------
  // Queues shared by stimulus, driver and monitor
  // ------------------------------------------------------------------
  in_t        pending [$];   // events waiting for the driver
  out_t       due [$];       // responses predicted, not yet seen
  logic [7:0] pat_bytes [$]; // text of the current expected pattern
  logic [7:0] line_buf [$];  // line under construction
  int         made  = 0;     // events generated so far
  int         fails = 0;

  // ------------------------------------------------------------------
  // Model state: registers, command state and the current line
  // ------------------------------------------------------------------
  bit [63:0] pat_word   = '0;
  bit [3:0]  pat_len    = '0;
  bit        cmd_busy   = 1'b0;
  int        stored_cnt = 0;     // bytes kept in the line buffer
  int        text_cnt   = 0;     // bytes ahead of the first NUL
  bit        nul_hit    = 1'b0;
  bit [7:0]  lead_byte  = '0;
  bit [7:0]  window [WIN_CELLS]; // newest text byte in cell 0
  bit        pat_seen   = 1'b0;
  bit        ok_seen    = 1'b0;
  bit        err_seen   = 1'b0;
  bit [31:0] ms_elapsed = '0;
  bit [31:0] ms_limit   = '0;

  task automatic line_reset();
    int j;
    stored_cnt = 0;
    text_cnt   = 0;
    nul_hit    = 1'b0;
    lead_byte  = '0;
    for (j = 0; j < WIN_CELLS; j++) window[j] = '0;
    pat_seen   = 1'b0;
    ok_seen    = 1'b0;
    err_seen   = 1'b0;
  endtask

  // True when the newest n text bytes equal the low n bytes of word.
  function automatic bit tail_matches(bit [63:0] word, int n);
    int j;
    if (n == 0 || n > WIN_CELLS || text_cnt < n) return 1'b0;
    for (j = 0; j < n; j++) begin
      if (window[j] != word[8*j +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic take_byte(bit [7:0] c);
    int j;
    int n;
    if (stored_cnt == 0) lead_byte = c;
    stored_cnt++;
    // everything from the first NUL on is kept out of the compare
    if (nul_hit) return;
    if (c == NUL_CODE) begin
      nul_hit = 1'b1;
      return;
    end
    for (j = WIN_CELLS - 1; j > 0; j--) window[j] = window[j-1];
    window[0] = c;
    text_cnt++;
    n = (pat_len > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : int'(pat_len);
    if (tail_matches(pat_word, n))          pat_seen = 1'b1;
    if (tail_matches(OK_WORD, OK_LEN))       ok_seen  = 1'b1;
    if (tail_matches(ERROR_WORD, ERROR_LEN)) err_seen = 1'b1;
  endtask

  // Advance the model by one event and queue the response it gives, if any.
  task automatic predict_response(in_t it);
    bit   blank;
    bit   has;
    int   tl;
    out_t r;
    has = 1'b0;
    r   = '0;
    case (it.action)
      ACT_BYTE: begin
        // 0xFF is never stored; a full line drops further bytes, LF included
        if (stored_cnt < LINE_BYTES_DEF - 1 && it.data_byte != SKIP_CODE)
          take_byte(it.data_byte);
        // LF ends the line whether or not it was stored
        if (it.data_byte == LF_CODE) begin
          blank = (text_cnt == 0) || (lead_byte == CR_CODE) || (lead_byte == LF_CODE);
          if (cmd_busy && !blank) begin
            tl  = (text_cnt > 255) ? 255 : text_cnt;
            has = 1'b1;
            if (pat_seen) begin
              r.result_kind   = KIND_PRIMARY;
              r.report_length = 8'(tl);
            end else if (ok_seen) begin
              r.result_kind   = KIND_OK;
              r.report_length = OK_REPORT;
              cmd_busy        = 1'b0;
            end else if (err_seen) begin
              r.result_kind   = KIND_ERROR;
              r.report_length = ERROR_REPORT;
              cmd_busy        = 1'b0;
            end else begin
              r.result_kind   = KIND_INTERMEDIATE;
              r.report_length = 8'(tl);
            end
          end
          line_reset();
        end
      end
      ACT_TICK: begin
        if (cmd_busy) begin
          if (ms_elapsed != 32'hFFFF_FFFF) ms_elapsed++;
          if (ms_elapsed >= ms_limit) begin
            cmd_busy        = 1'b0;
            has             = 1'b1;
            r.result_kind   = KIND_TIMEOUT;
            r.report_length = TIMEOUT_REPORT;
          end
        end
      end
      ACT_START: begin
        has = 1'b1;
        if (cmd_busy) begin
          r.result_kind = KIND_REFUSED;
        end else begin
          cmd_busy      = 1'b1;
          ms_elapsed    = '0;
          ms_limit      = it.tmo_ticks;
          r.result_kind = KIND_ACCEPTED;
        end
      end
      default: ;
    endcase
    if (has) due.push_back(r);
  endtask

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic void push_item(in_t it);
    pending.push_back(it);
    made++;
  endfunction

  // Unused fields carry random values so every bit gets both levels.
  function automatic void add_byte(logic [7:0] b);
    in_t it;
    it.action    = ACT_BYTE;
    it.data_byte = b;
    it.tmo_ticks = $urandom;
    push_item(it);
  endfunction

  function automatic void add_tick();
    in_t it;
    it.action    = ACT_TICK;
    it.data_byte = 8'($urandom);
    it.tmo_ticks = $urandom;
    push_item(it);
  endfunction

  function automatic void add_start(logic [31:0] t);
    in_t it;
    it.action    = ACT_START;
    it.data_byte = 8'($urandom);
    it.tmo_ticks = t;
    push_item(it);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_printable(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_buf.push_back(8'($urandom_range(32, 126)));
  endfunction

  // One line of modem text; without end_line it is left unterminated.
  function automatic void add_random_line(bit end_line);
    int k;
    int i;
    line_buf.delete();
    if ($urandom_range(99) < 6) line_buf.push_back(CR_CODE);  // reads as blank
    if ($urandom_range(99) < 25) put_printable(1, 5);
    k = $urandom_range(99);
    if (k < 25) begin
      for (i = 0; i < pat_bytes.size(); i++) line_buf.push_back(pat_bytes[i]);
    end else if (k < 45) put_text("OK");
    else if (k < 57) put_text("ERROR");
    else if (k < 63) put_text("+CME ERROR: 10");
    else if (k < 68) put_text("ERRO");
    else if (k < 72) put_text("O K");
    else if (k < 76) put_text("NO CARRIER");
    else put_printable(0, 10);
    if ($urandom_range(99) < 20) put_printable(1, 3);
    if (line_buf.size() != 0 && $urandom_range(99) < 6)
      line_buf.insert($urandom_range(0, line_buf.size() - 1), SKIP_CODE);
    if (line_buf.size() != 0 && $urandom_range(99) < 6)
      line_buf.insert($urandom_range(0, line_buf.size() - 1), NUL_CODE);
    if (end_line) begin
      if ($urandom_range(99) < 70) line_buf.push_back(CR_CODE);
      line_buf.push_back(LF_CODE);
    end
    for (i = 0; i < line_buf.size(); i++) add_byte(line_buf[i]);
  endfunction

  function automatic void pat_from(string s);
    int i;
    pat_bytes.delete();
    for (i = 0; i < s.len(); i++) pat_bytes.push_back(s[i]);
  endfunction

  // Register write; the model takes the value at the same edge as the block.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_EXPECT_PATTERN) pat_word = val;
    else pat_len = val[3:0];
  endtask

  // First pattern byte goes to the most significant used position; the
  // bytes above it may hold junk, which the block must ignore.
  task automatic apply_pattern(int len, bit junk);
    logic [63:0] v;
    int i;
    v = junk ? {$urandom, $urandom} : 64'd0;
    for (i = 0; i < len; i++) v[8*(len-1-i) +: 8] = pat_bytes[i];
    write_reg(REG_EXPECT_PATTERN, v);
    write_reg(REG_EXPECT_LENGTH, 64'(len));
  endtask

  // Quiet point: all sent, all responses in, then a few spare cycles.
  // Checked at the falling edge, once the rising-edge updates have settled.
  task automatic drain_wait();
    while (pending.size() != 0 || in_valid || due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Driver: one event per transfer, random gaps before each new one
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_response(in_data);
      // payload may only change once the current one has gone
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: every result transfer against the oldest prediction
  // ------------------------------------------------------------------
  out_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due.size() == 0) begin
          $error("result transfer with none expected: kind %0d length %0d",
                 out_data.result_kind, out_data.report_length);
          fails++;
        end else begin
          want = due.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d",
                   want.result_kind, out_data.result_kind);
            fails++;
          end
          if (out_data.report_length !== want.report_length) begin
            $error("report_length expected %0d actual %0d",
                   want.report_length, out_data.report_length);
            fails++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  initial begin
    int p;
    int k;
    int i;
    int start_mark;
    logic [31:0] t;

    line_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run, pattern match off (reset values).
    add_tick();                      // tick while idle: ignored
    add_text("OK\n");                // line while idle: dropped
    add_start(32'd0);                // accepted
    add_start(32'd5);                // refused, first command kept
    add_tick();                      // zero timeout fires on first tick
    add_start(32'hFFFF_FFFF);        // accepted, longest timeout
    add_text("\r\n");                // blank line
    add_text("OK\r\n");              // ok ends the command
    add_start(32'd3);
    add_byte("A");
    add_byte(NUL_CODE);              // text stops at the NUL: intermediate, 1
    add_text("OK\n");
    add_text("ERR");
    add_byte(SKIP_CODE);             // 0xFF dropped, ERROR still seen
    add_text("OR\n");
    drain_wait();                    // sender held until everything is back

    for (p = 0; p < 10; p++) begin
      // new setting, block idle
      case (p)
        0: begin pat_from("+CSQ:");    apply_pattern(5, 1'b0); end
        1: begin pat_from("CONNECT9"); apply_pattern(8, 1'b0); end
        2: begin
          // all-ones pattern with length zero: primary match off
          pat_from("OK");
          write_reg(REG_EXPECT_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_EXPECT_LENGTH, 64'd0);
        end
        3: begin pat_from("O");        apply_pattern(1, 1'b1); end  // overlaps OK
        4: begin
          // pattern holding a zero byte can never match
          pat_from("AB");
          write_reg(REG_EXPECT_PATTERN, 64'h0000_0000_0041_0042);
          write_reg(REG_EXPECT_LENGTH, 64'd3);
        end
        5: begin pat_from("ERROR");    apply_pattern(5, 1'b1); end  // beats ERROR
        9: begin pat_bytes.delete();   apply_pattern(0, 1'b0); end  // all zero
        default: begin
          pat_bytes.delete();
          repeat ($urandom_range(1, 8)) pat_bytes.push_back(8'($urandom_range(33, 90)));
          apply_pattern($urandom_range(0, pat_bytes.size()), 1'b1);
        end
      endcase

      start_mark = made;
      while (made - start_mark < PHASE_ITEMS) begin
        k = $urandom_range(99);
        if (k < 2 || (p == 4 && made == start_mark)) begin
          // over-long line: storage stops at 255 bytes, LF still ends it
          add_start(32'hFFFF_FFFF);
          repeat ($urandom_range(250, 270)) add_byte(8'($urandom_range(32, 126)));
          add_text("OK\r\n");
        end else if (k < 17) begin
          // noise and broken lines
          case ($urandom_range(3))
            0: add_byte(8'($urandom));
            1: add_tick();
            2: add_start($urandom);
            default: add_random_line(1'b0);
          endcase
        end else begin
          // command: start, then a few lines with ticks between them
          k = $urandom_range(99);
          if (k < 35)      t = $urandom_range(0, 5);
          else if (k < 85) t = $urandom_range(10, 300);
          else if (k < 95) t = $urandom;
          else             t = 32'hFFFF_FFFF;
          add_start(t);
          for (i = $urandom_range(1, 4); i > 0; i--) begin
            if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) add_tick();
            add_random_line(1'b1);
          end
        end
      end
      drain_wait();
    end

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> at_response_line_classifier.f
rtl/at_rlc_pkg.sv
rtl/at_rlc_cell.sv
rtl/at_rlc_outbuf.sv
rtl/at_response_line_classifier.sv
tb/sv/tb_top.sv
